>>> design/dsfu_pkg.sv
// Shared types, sizes and command codes for the dimer/spin flip-update block.
// Used by dsfu_alu and the top level; depends on nothing.
package dsfu_pkg;

  // Store sizes
  localparam int DIMER_COUNT = 4096;
  localparam int SITE_COUNT  = 2048;
  localparam int NEIGHBORS   = 3;

  localparam int DIMER_AW   = (DIMER_COUNT > 1) ? $clog2(DIMER_COUNT) : 1;
  localparam int SITE_AW    = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
  localparam int NMAP_DEPTH = SITE_COUNT * NEIGHBORS;
  localparam int NMAP_AW    = (NMAP_DEPTH > 1) ? $clog2(NMAP_DEPTH) : 1;
  localparam int SLOT_W     = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int KCNT_W     = $clog2(NEIGHBORS + 1);

  // Field widths
  localparam int CMD_W      = 3;
  localparam int INDEX_W    = 12;
  localparam int SLOTF_W    = 2;
  localparam int ND_W       = 12;
  localparam int COUPLING_W = 16;
  localparam int THR_W      = 5;
  localparam int NSUM_W     = 3;
  localparam int DELTA_W    = 19;
  localparam int ENERGY_W   = 40;
  localparam int CFG_IDX_W  = 1;

  // Internal arithmetic widths
  localparam int SUM_W  = $clog2(NEIGHBORS + 1) + 1;
  localparam int PROD_W = COUPLING_W + SUM_W + 1;

  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  // Commands
  localparam logic [CMD_W-1:0] CMD_WR_DIMER = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WR_SPIN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WR_NBR   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UPDATE   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_DIMER = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RD_SPIN  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic signed [COUPLING_W-1:0] COUPLING_RESET = 16'sd256;
  localparam logic signed [THR_W-1:0]      THRESHOLD_RESET = 5'sd0;

  // Operation strobes from the sequencer to the arithmetic unit
  typedef struct packed {
    logic sum_clr;
    logic sum_en;
    logic sum_bit;   // dimer state bit: 1 subtracts one, 0 adds one
    logic mul_en;
    logic acc_en;
    logic tot_clr;
  } dsfu_alu_ctl_t;

endpackage

>>> design/dsfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for all three stores of the flip-update block.
module dsfu_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/dsfu_alu.sv
// Shared arithmetic unit: neighbor sum, 2*J1*sum product, saturating energy total.
// Depends on dsfu_pkg; driven one operation at a time by the top-level sequencer.
module dsfu_alu
  import dsfu_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  dsfu_alu_ctl_t                ctl,
  input  logic signed [COUPLING_W-1:0] coupling,
  output logic signed [SUM_W-1:0]      sum,
  output logic signed [PROD_W-1:0]     delta,
  output logic signed [ENERGY_W-1:0]   total
);

  localparam logic signed [SUM_W-1:0] SUM_ONE = SUM_W'(1);

  logic signed [PROD_W-1:0]   prod;
  logic signed [ENERGY_W:0]   acc_sum;
  logic signed [ENERGY_W-1:0] total_next;

  assign prod    = (PROD_W'(coupling) * PROD_W'(sum)) <<< 1;
  assign acc_sum = {total[ENERGY_W-1], total} + (ENERGY_W+1)'(delta);

  always_comb begin
    total_next = acc_sum[ENERGY_W-1:0];
    if (acc_sum[ENERGY_W] != acc_sum[ENERGY_W-1]) begin
      total_next = acc_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sum_clr) begin
      sum <= '0;
    end else if (ctl.sum_en) begin
      sum <= ctl.sum_bit ? sum - SUM_ONE : sum + SUM_ONE;
    end
    if (ctl.mul_en) begin
      delta <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.tot_clr) begin
      total <= '0;
    end else if (ctl.acc_en) begin
      total <= total_next;
    end
  end

endmodule

>>> design/dimer_spin_flip_update.sv
// Top level of the dimer/spin flip-update block: command sequencer and stores.
// Depends on dsfu_pkg, dsfu_ram (three stores) and dsfu_alu (shared arithmetic).
//
// Commands arrive on s_axis (code in tuser, operands in tdata); each command
// yields exactly one result transfer on m_axis. Configuration (J1, flip
// threshold) is written through cfg_we/cfg_index/cfg_data; the user must write
// it only while idle, which the block does not enforce. One command is in
// flight at a time; s_axis_tready is high only when idle. After execute,
// reads pass a read-data state and an update of a stored site passes gather,
// decide and, on a flip, write-back before the result stage. The update uses
// the single read ports of the neighbor table and dimer store, one slot per
// cycle, pipelined two deep and drained, then one write-back per slot. tready
// returns the cycle after the load. A result waits in the output register
// while m_axis_tready is low; the next command is still accepted and runs up
// to its result stage, where it holds. Reset clears the sequencer, output
// valid and energy total and sets the configuration registers to their reset
// values. The stores are not cleared and have no clearing pass: an entry must
// be written before it is read or used by an update.
module dimer_spin_flip_update
  import dsfu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Command channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [31:0]          s_axis_tdata,  // index[11:0], slot[13:12],
                                              // bit_value[14], neighbor_dimer[26:15]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // cmd[2:0]
  // Result channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,  // read_value[0], flipped[1],
                                              // neighbor_sum[4:2], delta_energy[23:5],
                                              // energy_total[63:24]
  // Configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUPLING_W-1:0] cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDATA  = 3'd2;
  localparam logic [2:0] S_GATHER = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_FLIP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state, state_next;

  // Latched command
  logic [CMD_W-1:0]   cmd_q;
  logic [INDEX_W-1:0] idx_q;
  logic [SLOTF_W-1:0] slot_q;
  logic               bit_q;
  logic [ND_W-1:0]    nd_q;

  // Configuration
  logic signed [COUPLING_W-1:0] coupling;
  logic signed [THR_W-1:0]      thr;

  // Update bookkeeping
  logic [KCNT_W-1:0] issue_k;
  logic [SLOT_W-1:0] kk;
  logic              nm_pend, dm_pend, dm_ok;
  logic [SLOT_W-1:0] nm_slot, dm_slot;
  logic [ND_W-1:0]   nbr  [NEIGHBORS];
  logic              dbit [NEIGHBORS];
  logic              rv_q, flip_q, site_neg_q;
  logic              flip_par, dm_val, do_flip;

  // Store ports
  logic                dimer_we, dimer_wdata, dimer_rdata;
  logic [DIMER_AW-1:0] dimer_waddr, dimer_raddr;
  logic                spin_we, spin_rdata;
  logic                nmap_we;
  logic [NMAP_AW-1:0]  nmap_waddr, nmap_raddr;
  logic [ND_W-1:0]     nmap_rdata;

  // Arithmetic unit
  dsfu_alu_ctl_t             alu_ctl;
  logic signed [SUM_W-1:0]   alu_sum;
  logic signed [PROD_W-1:0]  alu_delta;
  logic signed [ENERGY_W-1:0] alu_total;

  // Result register
  logic                       out_valid, out_load;
  logic                       out_rv, out_flipped;
  logic signed [NSUM_W-1:0]   out_nsum;
  logic signed [DELTA_W-1:0]  out_delta;
  logic signed [ENERGY_W-1:0] out_total;

  logic site_ok, dimer_ok, slot_ok, in_accept;
  logic [31:0] nbr_base;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign site_ok  = 32'(idx_q) < SITE_COUNT;
  assign dimer_ok = 32'(idx_q) < DIMER_COUNT;
  assign slot_ok  = 32'(slot_q) < NEIGHBORS;
  assign nbr_base = 32'(idx_q) * NEIGHBORS;
  assign kk       = issue_k[SLOT_W-1:0];
  assign dm_val   = dm_ok && dimer_rdata;
  assign do_flip  = !spin_rdata && (32'(alu_sum) <= 32'(thr));
  assign out_load = (state == S_DONE) && (!out_valid || m_axis_tready);

  // Parity of the occurrences of this slot's dimer up to this slot: the last
  // write to a repeated dimer carries the net flip.
  always_comb begin
    flip_par = 1'b0;
    for (int j = 0; j < NEIGHBORS; j++) begin
      if (j <= int'(kk) && nbr[j] == nbr[kk]) begin
        flip_par = ~flip_par;
      end
    end
  end

  // Store and unit control
  always_comb begin
    dimer_we    = 1'b0;
    dimer_waddr = DIMER_AW'(idx_q);
    dimer_wdata = bit_q;
    dimer_raddr = DIMER_AW'(idx_q);
    spin_we     = 1'b0;
    nmap_we     = 1'b0;
    nmap_waddr  = NMAP_AW'(nbr_base + 32'(slot_q));
    nmap_raddr  = NMAP_AW'(nbr_base + 32'(issue_k));
    alu_ctl     = '0;
    alu_ctl.sum_bit = dm_val;
    state_next  = state;

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (cmd_q)
          CMD_WR_DIMER: dimer_we = dimer_ok;
          CMD_WR_SPIN:  spin_we  = site_ok;
          CMD_WR_NBR:   nmap_we  = site_ok && slot_ok;
          CMD_UPDATE: begin
            if (site_ok) begin
              alu_ctl.sum_clr = 1'b1;
              state_next = S_GATHER;
            end
          end
          CMD_RD_DIMER, CMD_RD_SPIN: state_next = S_RDATA;
          CMD_CLEAR:    alu_ctl.tot_clr = 1'b1;
          default: ;
        endcase
      end
      S_RDATA: state_next = S_DONE;
      S_GATHER: begin
        if (nm_pend) begin
          dimer_raddr = DIMER_AW'(nmap_rdata);
        end
        alu_ctl.sum_en = dm_pend;
        if (issue_k == KCNT_W'(NEIGHBORS) && !nm_pend && !dm_pend) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (do_flip) begin
          spin_we        = 1'b1;
          alu_ctl.mul_en = 1'b1;
          state_next     = S_FLIP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FLIP: begin
        dimer_we    = 32'(nbr[kk]) < DIMER_COUNT;
        dimer_waddr = DIMER_AW'(nbr[kk]);
        dimer_wdata = dbit[kk] ^ flip_par;
        alu_ctl.acc_en = (issue_k == '0);
        if (issue_k == KCNT_W'(NEIGHBORS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      coupling <= COUPLING_RESET;
      thr      <= THRESHOLD_RESET;
      nm_pend  <= 1'b0;
      dm_pend  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COUPLING:  coupling <= cfg_data;
          CFG_THRESHOLD: thr      <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (state == S_GATHER || (state == S_EXEC && cmd_q == CMD_UPDATE && site_ok)) begin
        nm_pend <= issue_k < KCNT_W'(NEIGHBORS);
        dm_pend <= nm_pend && (state == S_GATHER);
      end else begin
        nm_pend <= 1'b0;
        dm_pend <= 1'b0;
      end
    end
  end

  // Payload and bookkeeping registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q      <= s_axis_tuser;
      idx_q      <= s_axis_tdata[11:0];
      slot_q     <= s_axis_tdata[13:12];
      bit_q      <= s_axis_tdata[14];
      nd_q       <= s_axis_tdata[26:15];
      issue_k    <= '0;
      rv_q       <= 1'b0;
      flip_q     <= 1'b0;
      site_neg_q <= 1'b0;
    end
    case (state)
      S_EXEC: begin
        if (cmd_q == CMD_UPDATE && site_ok) begin
          issue_k <= issue_k + KCNT_W'(1);
          nm_slot <= kk;
        end
      end
      S_RDATA: begin
        rv_q <= (cmd_q == CMD_RD_DIMER) ? (dimer_ok && dimer_rdata)
                                        : (site_ok && spin_rdata);
      end
      S_GATHER: begin
        if (issue_k < KCNT_W'(NEIGHBORS)) begin
          issue_k <= issue_k + KCNT_W'(1);
          nm_slot <= kk;
        end
        if (nm_pend) begin
          nbr[nm_slot] <= nmap_rdata;
          dm_slot      <= nm_slot;
          dm_ok        <= 32'(nmap_rdata) < DIMER_COUNT;
        end
        if (dm_pend) begin
          dbit[dm_slot] <= dm_val;
        end
      end
      S_DECIDE: begin
        site_neg_q <= !spin_rdata;
        flip_q     <= do_flip;
        issue_k    <= '0;
      end
      S_FLIP: issue_k <= issue_k + KCNT_W'(1);
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rv      <= rv_q;
      out_flipped <= flip_q;
      out_nsum    <= site_neg_q ? NSUM_W'(alu_sum) : '0;
      out_delta   <= flip_q ? DELTA_W'(alu_delta) : '0;
      out_total   <= alu_total;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_total, out_delta, out_nsum, out_flipped, out_rv};

  dsfu_ram #(.WIDTH(1), .DEPTH(DIMER_COUNT)) u_dimer_ram (
    .clk   (clk),
    .we    (dimer_we),
    .waddr (dimer_waddr),
    .wdata (dimer_wdata),
    .raddr (dimer_raddr),
    .rdata (dimer_rdata)
  );

  dsfu_ram #(.WIDTH(1), .DEPTH(SITE_COUNT)) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (SITE_AW'(idx_q)),
    .wdata (cmd_q == CMD_UPDATE || bit_q),
    .raddr (SITE_AW'(idx_q)),
    .rdata (spin_rdata)
  );

  dsfu_ram #(.WIDTH(ND_W), .DEPTH(NMAP_DEPTH)) u_nmap_ram (
    .clk   (clk),
    .we    (nmap_we),
    .waddr (nmap_waddr),
    .wdata (nd_q),
    .raddr (nmap_raddr),
    .rdata (nmap_rdata)
  );

  dsfu_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .ctl      (alu_ctl),
    .coupling (coupling),
    .sum      (alu_sum),
    .delta    (alu_delta),
    .total    (alu_total)
  );

  // A reported flip always met the threshold in force
  a_flip_threshold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flipped |-> 32'(out_nsum) <= 32'(thr))
    else $error("flipped result above threshold");

  // Dimer write-back runs only for an update that flipped
  a_flip_state: assert property (@(posedge clk) disable iff (rst)
    state == S_FLIP |-> flip_q && cmd_q == CMD_UPDATE)
    else $error("flip write-back without a flip");

  // The energy total moves only on an accumulate or a clear
  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    !(alu_ctl.acc_en || alu_ctl.tot_clr) |=> $stable(alu_total))
    else $error("energy total changed without an operation");

endmodule
